/* hdl/lcd_bar_graph_redraw_top_macros.svh */
// Assertion macros for the bar-graph redraw block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LCD_BAR_GRAPH_REDRAW_TOP_MACROS_SVH
`define LCD_BAR_GRAPH_REDRAW_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define LBGR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LBGR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define LBGR_ASSERT_NOW(lbl, ante, cons)
`define LBGR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hdl/lbgr_pkg.sv */
`timescale 1ns / 1ps

package lbgr_pkg;

  // Bar geometry: the bar has 2**BAR_SHIFT cells.
  localparam int BAR_SHIFT   = 4;
  localparam int BAR_CELLS   = 1 << BAR_SHIFT;
  localparam int CELL_W      = BAR_SHIFT + 1;
  localparam int SAMPLE_BITS = 10;
  localparam int FS_W        = 10;
  localparam int REM_W       = FS_W + 1;
  localparam int STEP_W      = (BAR_SHIFT > 1) ? $clog2(BAR_SHIFT) : 1;

  // Display codes.
  localparam logic [7:0] CH_FILLED     = 8'h6f;
  localparam logic [7:0] CH_EMPTY      = 8'h5f;
  localparam logic [7:0] ROW2_ADDR     = 8'h40;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  localparam logic [FS_W-1:0] FULL_SCALE_RESET = 10'd145;

  // Register-select codes on the bus.
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Mode codes of an input item.
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_FULL   = 1'b1;

  // Job queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic                   func;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } out_item_t;

  // One drawing job: first cell, number of cells, and the bar length that
  // decides filled or empty for each cell.
  typedef struct packed {
    logic [CELL_W-1:0] start;
    logic [CELL_W-1:0] count;
    logic [CELL_W-1:0] len;
  } job_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CMD,
    BK_DATA
  } back_state_t;

endpackage

/* hdl/lbgr_front.sv */
`timescale 1ns / 1ps

module lbgr_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  lbgr_pkg::in_item_t        in_item,
  input  logic                      cfg_valid,
  input  logic [lbgr_pkg::FS_W-1:0] cfg_data,
  output logic                      job_valid,
  input  logic                      job_ready,
  output lbgr_pkg::job_t            job
);
  import lbgr_pkg::*;

  front_state_t       state_r, state_nxt;
  logic [FS_W-1:0]    full_scale_r;
  logic [CELL_W-1:0]  shown_r;
  logic               func_r;
  logic               sat_r;
  logic [REM_W-1:0]   rem_r;
  logic [BAR_SHIFT-1:0] quo_r;
  logic [STEP_W-1:0]  step_r;

  logic               in_acc;
  logic               push_fire;
  logic               last_step;
  logic [REM_W:0]     rem2;
  logic [REM_W:0]     fs_ext;
  logic               ge;
  logic [REM_W:0]     diff;
  logic [CELL_W-1:0]  len;

  assign in_acc    = in_push && !in_full;
  assign push_fire = job_valid && job_ready;
  assign last_step = (step_r == STEP_W'(BAR_SHIFT - 1));

  // One restoring division step: the quotient of sample*BAR_CELLS/full_scale
  // is built one bit a cycle, starting from a remainder below the divisor.
  assign rem2   = {rem_r, 1'b0};
  assign fs_ext = {{(REM_W + 1 - FS_W){1'b0}}, full_scale_r};
  assign ge     = (rem2 >= fs_ext);
  assign diff   = rem2 - fs_ext;

  // A sample at or above full scale (including a full scale of zero) fills the bar.
  assign len = sat_r ? CELL_W'(BAR_CELLS) : {1'b0, quo_r};

  // Classify the item into the cells to redraw.
  always_comb begin
    job.len = len;
    if (func_r == FUNC_FULL) begin
      job.start = '0;
      job.count = CELL_W'(BAR_CELLS);
    end else if (len > shown_r) begin
      job.start = shown_r;
      job.count = len - shown_r;
    end else begin
      job.start = len;
      job.count = shown_r - len;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_IDLE: begin
        if (in_push) begin
          state_nxt = (in_item.sample >= full_scale_r) ? FR_PUSH : FR_DIV;
        end
      end
      FR_DIV: begin
        if (last_step) begin
          state_nxt = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (job_ready) begin
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_full   = 1'b1;
    job_valid = 1'b0;
    unique case (state_r)
      FR_IDLE: in_full   = 1'b0;
      FR_DIV:  in_full   = 1'b1;
      FR_PUSH: job_valid = 1'b1;
      default: in_full   = 1'b1;
    endcase
  end

  // Control state, the full-scale register and the shown bar length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FR_IDLE;
      full_scale_r <= FULL_SCALE_RESET;
      shown_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        full_scale_r <= cfg_data;
      end
      if (push_fire) begin
        shown_r <= len;
      end
    end
  end

  // Division datapath.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_item.func;
      sat_r  <= (in_item.sample >= full_scale_r);
      rem_r  <= {{(REM_W - SAMPLE_BITS){1'b0}}, in_item.sample};
      quo_r  <= '0;
      step_r <= '0;
    end else if (state_r == FR_DIV) begin
      rem_r  <= ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
      quo_r  <= {quo_r[BAR_SHIFT-2:0], ge};
      step_r <= step_r + STEP_W'(1);
    end
  end

endmodule

/* hdl/lbgr_queue.sv */
`timescale 1ns / 1ps

module lbgr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  lbgr_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lbgr_pkg::job_t pop_data
);
  import lbgr_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/lbgr_back.sv */
`timescale 1ns / 1ps

module lbgr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_pop,
  input  lbgr_pkg::job_t      job,
  output logic                out_empty,
  input  logic                out_pop,
  output lbgr_pkg::out_item_t out_item
);
  import lbgr_pkg::*;

  back_state_t       state_r, state_nxt;
  logic              lo_r;
  logic [CELL_W-1:0] pos_r;
  logic [CELL_W-1:0] left_r;
  logic [CELL_W-1:0] len_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              emit;
  logic [7:0]        byte_val;
  out_item_t         item_nxt;

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          state_nxt = BK_CMD;
        end
      end
      BK_CMD: begin
        if (emit && lo_r) begin
          state_nxt = (left_r == '0) ? BK_IDLE : BK_DATA;
        end
      end
      BK_DATA: begin
        if (emit && lo_r && (left_r == '0)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs: the byte for the current position and the nibble taken from it.
  always_comb begin
    job_pop  = 1'b0;
    emit     = 1'b0;
    byte_val = CH_EMPTY;
    item_nxt.reg_select = RS_DATA;
    unique case (state_r)
      BK_IDLE: begin
        job_pop = 1'b1;
      end
      BK_CMD: begin
        emit     = !out_valid_r || out_pop;
        byte_val = CMD_SET_DDRAM | (ROW2_ADDR + {{(8 - CELL_W){1'b0}}, pos_r});
        item_nxt.reg_select = RS_CMD;
      end
      BK_DATA: begin
        emit     = !out_valid_r || out_pop;
        byte_val = (pos_r < len_r) ? CH_FILLED : CH_EMPTY;
      end
      default: job_pop = 1'b0;
    endcase
    item_nxt.nibble = lo_r ? byte_val[3:0] : byte_val[7:4];
    item_nxt.last   = lo_r && (left_r == '0);
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      lo_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_IDLE) begin
        lo_r <= 1'b0;
      end else if (emit) begin
        lo_r <= !lo_r;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Position, cells left after the current byte, and the output register.
  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE) begin
      if (job_valid) begin
        pos_r  <= job.start;
        left_r <= job.count;
        len_r  <= job.len;
      end
    end else if (emit && lo_r) begin
      left_r <= left_r - CELL_W'(1);
      if (state_r == BK_DATA) begin
        pos_r <= pos_r + CELL_W'(1);
      end
    end
    if (emit) begin
      out_item_r <= item_nxt;
    end
  end

endmodule

/* hdl/lcd_bar_graph_redraw_top.sv */
`timescale 1ns / 1ps
`include "lcd_bar_graph_redraw_top_macros.svh"

// Bar-graph redraw for a character LCD on a 4-bit bus. Each item carries a
// mode and a sample; the bar length is sample*16/full_scale, saturated at 16
// cells, and the block emits the nibble writes that draw it on row two: a
// set-address command and then the cells, every byte as high then low
// nibble, with the last nibble of each item flagged. A full redraw gives 34
// nibbles; an update gives 2 plus 2 per changed cell. The output side
// delivers one nibble per cycle while each nibble is popped, and the
// sequencer returns to its idle state between items to fetch the next job.
// The front end handles an item in steps (accept, four steps of a
// one-bit-per-cycle divider that saturated samples skip, queue push) and runs ahead of the
// back end through a two-entry job queue. The full-scale register is written
// through the cfg_ channel, which is always ready; write it only while idle.
module lcd_bar_graph_redraw_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  lbgr_pkg::in_item_t        in_item,
  output logic                      out_empty,
  input  logic                      out_pop,
  output lbgr_pkg::out_item_t       out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lbgr_pkg::FS_W-1:0] cfg_data
);
  import lbgr_pkg::*;

  logic            fr_valid;
  logic            fr_ready;
  job_t            fr_job;
  logic            bk_valid;
  logic            bk_pop;
  job_t            bk_job;
  logic            in_acc;
  logic            fr_fire;
  logic [CELL_W:0] job_end;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_push && !in_full;
  assign fr_fire   = fr_valid && fr_ready;
  assign job_end   = {1'b0, fr_job.start} + {1'b0, fr_job.count};

  // Front part: takes items, divides and classifies them into jobs.
  lbgr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  // Job queue between the two parts.
  lbgr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_job),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_pop),
    .pop_data   (bk_job)
  );

  // Back part: turns jobs into bus nibbles.
  lbgr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (bk_valid),
    .job_pop   (bk_pop),
    .job       (bk_job),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // The front part works on one item at a time.
  `LBGR_ASSERT_NEXT(a_front_busy, in_acc, in_full)
  // A job never runs past the end of the bar.
  `LBGR_ASSERT_NOW(a_job_in_bar, fr_fire, job_end <= (CELL_W + 1)'(BAR_CELLS))
  // Character nibbles are only those of the filled and empty glyphs.
  `LBGR_ASSERT_NOW(a_data_nibble, !out_empty && (out_item.reg_select == RS_DATA),
    (out_item.nibble == 4'h6) || (out_item.nibble == 4'h5) || (out_item.nibble == 4'hf))

endmodule
